// ===== design/rbd_pkg.sv =====
`default_nettype none

package rbd_pkg;

  // field widths
  localparam int unsigned ReasonW   = 8;
  localparam int unsigned RetryW    = 16;
  localparam int unsigned RandW     = 32;
  localparam int unsigned DelayW    = 32;
  localparam int unsigned CapW      = 30;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = ReasonW + RetryW + RandW;

  // jitter divisor is 2W, with W = base >> 2 (base[CapW-1:2] with a zero below it)
  localparam int unsigned DvsrW     = CapW - 1;
  localparam int unsigned NumCells  = RandW;

  localparam logic [CapW-1:0]   BaseUnitMs   = CapW'(1000);
  // 1000 << 21 exceeds any 30-bit cap
  localparam logic [ShiftW-1:0] MaxFreeShift = ShiftW'(20);

  localparam logic [CapW-1:0]   LinkCapRst   = CapW'(60000);
  localparam logic [CapW-1:0]   SecCapRst    = CapW'(300000);
  localparam logic [ShiftW-1:0] ShiftLimRst  = ShiftW'(6);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINK_CAP  = 2'd0,
    CFG_SEC_CAP   = 2'd1,
    CFG_SHIFT_LIM = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  // data handed from cell to cell of the remainder chain
  typedef struct packed {
    logic [DvsrW-1:0] rem;
    logic [RandW-1:0] dvd;
    logic [DvsrW-1:0] dvsr;
    logic [CapW-1:0]  base;
    logic             sec;
  } rbd_stage_t;

  function automatic logic is_security_reason(input logic [ReasonW-1:0] code);
    logic res;
    unique case (code)
      8'd2,
      8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20,
      8'd23, 8'd24, 8'd29, 8'd49,
      8'd202, 8'd203, 8'd204, 8'd210, 8'd211: res = 1'b1;
      default:                                res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/rbd_front.sv =====
`default_nettype none

module rbd_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire                          valid_i,
  input  wire  [rbd_pkg::ReasonW-1:0]  reason_code_i,
  input  wire  [rbd_pkg::RetryW-1:0]   retry_count_i,
  input  wire  [rbd_pkg::RandW-1:0]    random_word_i,
  input  wire  [rbd_pkg::CapW-1:0]     link_cap_i,
  input  wire  [rbd_pkg::CapW-1:0]     sec_cap_i,
  input  wire  [rbd_pkg::ShiftW-1:0]   shift_lim_i,
  output logic                         valid_o,
  output rbd_pkg::rbd_stage_t          stage_o
);
  import rbd_pkg::*;

  logic                sec;
  logic [RetryW-1:0]   retry_m1;
  logic [ShiftW-1:0]   eff_shift;
  logic [CapW-1:0]     cap;
  logic [CapW-1:0]     raw;
  logic [CapW-1:0]     base;
  logic                valid_q;
  rbd_stage_t          stage_d;
  rbd_stage_t          stage_q;

  always_comb begin
    sec       = is_security_reason(reason_code_i);
    retry_m1  = retry_count_i - RetryW'(1);
    eff_shift = (retry_m1 > RetryW'(shift_lim_i)) ? shift_lim_i : retry_m1[ShiftW-1:0];
    cap       = sec ? sec_cap_i : link_cap_i;
    raw       = BaseUnitMs << eff_shift;
    if (retry_count_i == '0) begin
      base = '0;
    end else if (eff_shift > MaxFreeShift) begin
      base = cap;
    end else begin
      base = (raw > cap) ? cap : raw;
    end
    stage_d.rem  = '0;
    stage_d.dvd  = random_word_i;
    stage_d.dvsr = {base[CapW-1:2], 1'b0};
    stage_d.base = base;
    stage_d.sec  = sec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== design/rbd_mod_cell.sv =====
`default_nettype none

module rbd_mod_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  adv_i,
  input  wire                  valid_i,
  input  wire rbd_pkg::rbd_stage_t stage_i,
  output logic                 valid_o,
  output rbd_pkg::rbd_stage_t  stage_o
);
  import rbd_pkg::*;

  logic [DvsrW:0]   shifted;
  logic [DvsrW+1:0] diff;
  rbd_stage_t       stage_d;
  rbd_stage_t       stage_q;
  logic             valid_q;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted      = {stage_i.rem, stage_i.dvd[RandW-1]};
    diff         = {1'b0, shifted} - {2'b0, stage_i.dvsr};
    stage_d      = stage_i;
    stage_d.dvd  = {stage_i.dvd[RandW-2:0], 1'b0};
    stage_d.rem  = diff[DvsrW+1] ? shifted[DvsrW-1:0] : diff[DvsrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== design/reconnect_backoff_delay_unit.sv =====
// Reconnect backoff delay unit: exponential backoff with jitter.
// Input stream (s_axis_*): one transaction per disconnect event, tdata holds
// reason_code [7:0], retry_count [23:8] and random_word [55:24].
// Output stream (m_axis_*): one transaction per input, tdata holds delay_ms
// and tuser holds is_security.
// Config channel (cfg_*): index 0 link cap, 1 security cap, 2 shift limit;
// always ready, write only while no transaction is in flight.
// Pipeline: the edge that accepts an input loads classification and base into
// the front register, then the 32 cells of the remainder chain take one dividend
// bit each, and the output register takes the final sum.
// Throughput: one transaction per cycle; the whole pipeline advances
// together, so a new input is taken every cycle the output is free or taken.
// Stall: while the output holds a result and m_axis_tready_i is low, the
// pipeline freezes and s_axis_tready_o drops; nothing is lost.
// Reset: all valid bits clear, the registers return to 60000 / 300000 / 6.
`default_nettype none

module reconnect_backoff_delay_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // reason_code [7:0], retry_count [23:8], random_word [55:24]
  input  wire  [rbd_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // delay_ms [31:0]
  output logic [rbd_pkg::DelayW-1:0]   m_axis_tdata_o,
  // is_security [0]
  output logic                         m_axis_tuser_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [rbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [rbd_pkg::CapW-1:0]     cfg_data_i
);
  import rbd_pkg::*;

  logic [CapW-1:0]   link_cap_q;
  logic [CapW-1:0]   sec_cap_q;
  logic [ShiftW-1:0] shift_lim_q;
  logic              adv;
  logic              out_valid_q;
  logic [DelayW-1:0] delay_d;
  logic [DelayW-1:0] delay_q;
  logic              sec_q;
  logic [CapW-3:0]   win;

  rbd_stage_t        chain   [NumCells+1];
  logic              chain_v [NumCells+1];
  rbd_stage_t        last;

  assign cfg_ready_o     = 1'b1;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_cap_q  <= LinkCapRst;
      sec_cap_q   <= SecCapRst;
      shift_lim_q <= ShiftLimRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LINK_CAP:  link_cap_q  <= cfg_data_i;
        CFG_SEC_CAP:   sec_cap_q   <= cfg_data_i;
        CFG_SHIFT_LIM: shift_lim_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  rbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (s_axis_tvalid_i),
    .reason_code_i (s_axis_tdata_i[ReasonW-1:0]),
    .retry_count_i (s_axis_tdata_i[ReasonW+RetryW-1:ReasonW]),
    .random_word_i (s_axis_tdata_i[InDataW-1:ReasonW+RetryW]),
    .link_cap_i    (link_cap_q),
    .sec_cap_i     (sec_cap_q),
    .shift_lim_i   (shift_lim_q),
    .valid_o       (chain_v[0]),
    .stage_o       (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rbd_mod_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_v[i]),
      .stage_i (chain[i]),
      .valid_o (chain_v[i+1]),
      .stage_o (chain[i+1])
    );
  end

  assign last = chain[NumCells];

  // base + (rnd mod 2W) - W, or base alone when W is zero; never below zero and never past 2^31
  always_comb begin
    win = last.base[CapW-1:2];
    if (win == '0) begin
      delay_d = DelayW'(last.base);
    end else begin
      delay_d = DelayW'(last.base) + DelayW'(last.rem) - DelayW'(win);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain_v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      delay_q <= delay_d;
      sec_q   <= last.sec;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = delay_q;
  assign m_axis_tuser_o  = sec_q;

`ifndef ASSERT_OFF
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output backpressure");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_v[NumCells] && last.dvsr != '0) |-> (last.rem < last.dvsr))
    else $error("remainder chain left a value not below the divisor");

  a_delay_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o < 32'h5000_0000))
    else $error("delay beyond base plus window");

  a_base_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[0] |-> (chain[0].base <= (chain[0].sec ? sec_cap_q : link_cap_q)))
    else $error("base delay above selected cap");
`endif

endmodule

`default_nettype wire
